FILE: hdl/spq_pkg.sv
package spq_pkg;

	// Field widths of the request and response words.
	localparam int OP_W     = 2;
	localparam int KEY_W    = 16;
	localparam int PAY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;

	// Default number of cells in the chain.
	localparam int DEPTH_DEF = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
	localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Command broadcast from the control logic to every cell.
	typedef struct packed {
		logic             offer;
		logic             poll;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} cell_cmd_t;

endpackage

FILE: hdl/spq_ifs.sv
// Request channel: one operation per word.
interface spq_req_if;
	logic                      valid;
	logic                      ready;
	logic [spq_pkg::OP_W-1:0]  op;
	logic [spq_pkg::KEY_W-1:0] key;
	logic [spq_pkg::PAY_W-1:0] payload;

	modport source (output valid, output op, output key, output payload, input ready);
	modport sink (input valid, input op, input key, input payload, output ready);
endinterface

// Response channel: one result word per request word.
interface spq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [spq_pkg::STATUS_W-1:0] status;
	logic [spq_pkg::POS_W-1:0]    position;
	logic [spq_pkg::KEY_W-1:0]    head_key;
	logic [spq_pkg::PAY_W-1:0]    head_payload;
	logic [spq_pkg::CNT_W-1:0]    count;

	modport source (output valid, output status, output position, output head_key,
		output head_payload, output count, input ready);
	modport sink (input valid, input status, input position, input head_key,
		input head_payload, input count, output ready);
endinterface

FILE: hdl/sorted_priority_queue.sv
// Channel  Dir  Handshake    Word
// req      in   valid/ready  op, key, payload
// rsp      out  valid/ready  status, position, head_key, head_payload, count
//
// One request word is taken per cycle while the response side is not stalled;
// its result appears in the response register on the next cycle. The chain of cells
// compares every held key against the offered key at once and shifts in the same edge.
// Reset clears the occupancy count and the response valid flag only; cell
// contents and result fields are meaningless until written. A stalled
// response holds the request side for as long as the response register stays full.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spq_req_if.sink       req,
	spq_rsp_if.source     rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [CW-1:0]             occ_q;
	logic [CW-1:0]             occ_next;
	logic                      take;
	logic                      is_full;
	logic                      is_empty;
	spq_pkg::cell_cmd_t        cmd;
	logic [IW-1:0]             pos;

	logic                      ins      [DEPTH];
	logic                      edge_hit [DEPTH];
	logic [spq_pkg::KEY_W-1:0] cell_key [DEPTH];
	logic [spq_pkg::PAY_W-1:0] cell_pay [DEPTH];

	logic                         rsp_valid_q;
	logic [spq_pkg::STATUS_W-1:0] status_q;
	logic [spq_pkg::POS_W-1:0]    position_q;
	logic [spq_pkg::KEY_W-1:0]    head_key_q;
	logic [spq_pkg::PAY_W-1:0]    head_payload_q;
	logic [spq_pkg::CNT_W-1:0]    count_q;

	// Request side handshake.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;
	assign is_full   = (occ_q == CW'(DEPTH));
	assign is_empty  = (occ_q == '0);

	// Command sent down the chain.
	always_comb begin
		cmd.offer   = take && (req.op == spq_pkg::OP_OFFER) && !is_full;
		cmd.poll    = take && (req.op == spq_pkg::OP_POLL) && !is_empty;
		cmd.key     = req.key;
		cmd.payload = req.payload;
	end

	// Chain of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      l_ins;
		logic [spq_pkg::KEY_W-1:0] l_key;
		logic [spq_pkg::PAY_W-1:0] l_pay;
		logic [spq_pkg::KEY_W-1:0] r_key;
		logic [spq_pkg::PAY_W-1:0] r_pay;

		if (i == 0) begin : g_first
			assign l_ins = 1'b0;
			assign l_key = req.key;
			assign l_pay = req.payload;
		end else begin : g_mid
			assign l_ins = ins[i-1];
			assign l_key = cell_key[i-1];
			assign l_pay = cell_pay[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_key = cell_key[i];
			assign r_pay = cell_pay[i];
		end else begin : g_inner
			assign r_key = cell_key[i+1];
			assign r_pay = cell_pay[i+1];
		end

		spq_cell #(.DEPTH(DEPTH), .INDEX(i), .CW(CW)) u_cell (
			.clk           (clk),
			.cmd           (cmd),
			.occ           (occ_q),
			.left_ins      (l_ins),
			.left_key      (l_key),
			.left_payload  (l_pay),
			.right_key     (r_key),
			.right_payload (r_pay),
			.ins           (ins[i]),
			.edge_hit      (edge_hit[i]),
			.key_q         (cell_key[i]),
			.payload_q     (cell_pay[i])
		);
	end

	// Insert position: at most one cell reports the step edge (exactly one
	// unless the chain is full), so its index is recovered by OR-ing the flagged indices.
	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (edge_hit[i]) begin
				pos = pos | IW'(i);
			end
		end
	end

	// Occupancy after this word.
	always_comb begin
		occ_next = occ_q;
		if (cmd.offer) begin
			occ_next = occ_q + CW'(1);
		end else if (cmd.poll) begin
			occ_next = occ_q - CW'(1);
		end
	end

	// Occupancy count and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_next;
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result fields, loaded when a word is taken.
	always_ff @(posedge clk) begin
		if (take) begin
			status_q       <= spq_pkg::ST_OK;
			position_q     <= '0;
			head_key_q     <= '0;
			head_payload_q <= '0;
			count_q        <= spq_pkg::CNT_W'(occ_next);
			case (req.op)
				spq_pkg::OP_OFFER: begin
					if (is_full) begin
						status_q <= spq_pkg::ST_FULL;
					end else begin
						position_q <= spq_pkg::POS_W'(pos);
					end
				end
				spq_pkg::OP_POLL, spq_pkg::OP_PEEK: begin
					if (is_empty) begin
						status_q <= spq_pkg::ST_EMPTY;
					end else begin
						head_key_q     <= cell_key[0];
						head_payload_q <= cell_pay[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.position     = position_q;
	assign rsp.head_key     = head_key_q;
	assign rsp.head_payload = head_payload_q;
	assign rsp.count        = count_q;

endmodule

FILE: hdl/spq_cell.sv
module spq_cell #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int INDEX = 0,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  spq_pkg::cell_cmd_t        cmd,
	input  logic [CW-1:0]             occ,
	input  logic                      left_ins,
	input  logic [spq_pkg::KEY_W-1:0] left_key,
	input  logic [spq_pkg::PAY_W-1:0] left_payload,
	input  logic [spq_pkg::KEY_W-1:0] right_key,
	input  logic [spq_pkg::PAY_W-1:0] right_payload,
	output logic                      ins,
	output logic                      edge_hit,
	output logic [spq_pkg::KEY_W-1:0] key_q,
	output logic [spq_pkg::PAY_W-1:0] payload_q
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	// A cell lies at or right of the insert point when it is empty or holds a
	// larger key. Since the chain is sorted, this flag steps from 0 to 1 once.
	assign ins      = (IDX >= occ) || (cmd.key < key_q);
	assign edge_hit = ins && !left_ins;

	// On an offer, cells right of the insert point shift right and the cell at
	// the insert point takes the new entry. On a poll, every cell shifts left.
	always_ff @(posedge clk) begin
		if (cmd.offer) begin
			if (left_ins) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end else if (ins) begin
				key_q     <= cmd.key;
				payload_q <= cmd.payload;
			end
		end else if (cmd.poll) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

endmodule

FILE: dv/tb.sv
module tb;
	import spq_pkg::*;

	// Op code three is not a queue operation; the block must leave its state alone.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [KEY_W-1:0]    head_key;
		logic [PAY_W-1:0]    head_payload;
		logic [CNT_W-1:0]    count;
	} rsp_word_t;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_PEEKY} mix_t;

	// Tracks the sorted contents of the queue and the responses still owed by the block.
	class spq_scoreboard;
		logic [KEY_W-1:0] held_key [DEPTH];
		logic [PAY_W-1:0] held_pay [DEPTH];
		int               held_cnt;
		rsp_word_t        predicted_rsp [$];
		int               errors;
		int               rsp_num;

		function new();
			held_cnt = 0;
			errors   = 0;
			rsp_num  = 0;
		endfunction

		// Applies one operation to the sorted list and returns the response it should give.
		function rsp_word_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
				logic [PAY_W-1:0] pay);
			rsp_word_t r;
			int        slot;
			int        i;
			r = '0;
			case (op)
				OP_OFFER: begin
					if (held_cnt >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// The new entry goes in front of the first strictly larger key.
						slot = held_cnt;
						for (i = held_cnt - 1; i >= 0; i--)
							if (key < held_key[i])
								slot = i;
						for (i = held_cnt; i > slot; i--) begin
							held_key[i] = held_key[i-1];
							held_pay[i] = held_pay[i-1];
						end
						held_key[slot] = key;
						held_pay[slot] = pay;
						held_cnt++;
						r.status   = ST_OK;
						r.position = slot[POS_W-1:0];
					end
				end
				OP_POLL, OP_PEEK: begin
					if (held_cnt == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.status       = ST_OK;
						r.head_key     = held_key[0];
						r.head_payload = held_pay[0];
						if (op == OP_POLL) begin
							for (i = 1; i < held_cnt; i++) begin
								held_key[i-1] = held_key[i];
								held_pay[i-1] = held_pay[i];
							end
							held_cnt--;
						end
					end
				end
				default: begin
					r.status = ST_OK;
				end
			endcase
			r.count = held_cnt[CNT_W-1:0];
			return r;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
				logic [PAY_W-1:0] pay);
			predicted_rsp.push_back(apply_op(op, key, pay));
		endfunction

		function int pending();
			return predicted_rsp.size();
		endfunction

		task report(string msg);
			$display("ERROR: response %0d: %s", rsp_num, msg);
			errors++;
		endtask

		task check_response(rsp_word_t got);
			rsp_word_t want;
			if (predicted_rsp.size() == 0) begin
				report("response word with no request outstanding");
			end else begin
				want = predicted_rsp.pop_front();
				if (got.status !== want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.position !== want.position)
					report($sformatf("position got %0d want %0d", got.position,
						want.position));
				if (got.head_key !== want.head_key)
					report($sformatf("head_key got 0x%h want 0x%h", got.head_key,
						want.head_key));
				if (got.head_payload !== want.head_payload)
					report($sformatf("head_payload got 0x%h want 0x%h", got.head_payload,
						want.head_payload));
				if (got.count !== want.count)
					report($sformatf("count got %0d want %0d", got.count, want.count));
			end
			rsp_num++;
		endtask
	endclass

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	spq_scoreboard sb = new();

	bit        tx_burst;
	int        rx_hold_cycles;
	int        cycle_cnt;
	rsp_word_t seen_rsp;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit in case the block hangs.
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("** sorted_priority_queue: FAILED **");
			$finish;
		end
	end

	// Watch both channels; a request is noted before a response of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.op, req_ch.key, req_ch.payload);
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_rsp = {rsp_ch.status, rsp_ch.position, rsp_ch.head_key,
					rsp_ch.head_payload, rsp_ch.count};
				sb.check_response(seen_rsp);
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Small keys produce plenty of ties, which exercise arrival order among equal keys.
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return KEY_W'($urandom_range(0, 7));
		if (roll < 45)
			return $urandom_range(0, 1) ? '1 : '0;
		return KEY_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [PAY_W-1:0] pick_payload();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return '0;
		if (roll < 10)
			return '1;
		return $urandom;
	endfunction

	// Response side: random stalls, quiet stretches, and a long hold-off on request.
	initial begin
		int stall;
		int mode_left;
		bit rx_burst;
		stall          = 0;
		mode_left      = 0;
		rx_burst       = 1'b0;
		rx_hold_cycles = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				rx_burst  = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (rx_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold_cycles--;
			end else if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!rx_burst)
					stall = pick_gap();
			end
		end
	end

	// Offer one request word and hold it until the block takes it.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay);
		int gap;
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.key     <= key;
		req_ch.payload <= pay;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending until every owed response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input mix_t mode);
		int               roll;
		int               offer_pct;
		int               poll_pct;
		logic [OP_W-1:0]  op;
		case (mode)
			MIX_FILL:     begin offer_pct = 80; poll_pct = 12; end
			MIX_DRAIN:    begin offer_pct = 15; poll_pct = 70; end
			MIX_BALANCED: begin offer_pct = 45; poll_pct = 40; end
			default:      begin offer_pct = 35; poll_pct = 25; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll == 99)
			op = OP_UNUSED;
		else if (roll < offer_pct)
			op = OP_OFFER;
		else if (roll < offer_pct + poll_pct)
			op = OP_POLL;
		else
			op = OP_PEEK;
		send_word(op, pick_key(), pick_payload());
	endtask

	// Main stimulus.
	initial begin
		int   sent;
		int   chunk;
		int   len;
		int   n;
		mix_t mode;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.op      <= OP_OFFER;
		req_ch.key     <= '0;
		req_ch.payload <= '0;
		tx_burst = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty queue, unused op, extreme keys and payloads, ties, then emptying.
		send_word(OP_POLL, '0, '0);
		send_word(OP_PEEK, '1, '1);
		send_word(OP_UNUSED, 16'h1234, 32'h5678_9abc);
		send_word(OP_OFFER, '1, '1);
		send_word(OP_OFFER, '0, '0);
		send_word(OP_OFFER, '0, 32'h0000_0001);
		send_word(OP_OFFER, 16'h8000, 32'h8000_0000);
		send_word(OP_OFFER, 16'hfffe, 32'hdead_beef);
		send_word(OP_PEEK, '0, '0);
		send_word(OP_UNUSED, '1, '1);
		send_word(OP_POLL, '0, '0);
		send_word(OP_POLL, '0, '0);
		send_word(OP_PEEK, '0, '0);
		send_word(OP_POLL, '0, '0);
		send_word(OP_POLL, '0, '0);
		send_word(OP_POLL, '0, '0);
		send_word(OP_POLL, '0, '0);
		send_word(OP_PEEK, '0, '0);
		wait_drained();

		// Random chunks, each with its own operation mix; full and empty both come up often.
		sent  = 0;
		chunk = 0;
		while (sent < RANDOM_ITEMS) begin
			if (chunk == 0)
				mode = MIX_FILL;
			else if (chunk == 1)
				mode = MIX_DRAIN;
			else
				mode = mix_t'($urandom_range(0, 3));
			tx_burst = ($urandom_range(0, 4) == 0);
			len      = $urandom_range(30, 90);
			// Hold the response side off while requests keep coming, so the block backs up.
			if (chunk == 4) begin
				rx_hold_cycles = HOLD_CYCLES;
				tx_burst       = 1'b1;
			end
			for (n = 0; n < len; n++)
				send_random(mode);
			sent += len;
			if (chunk == 2 || chunk % 9 == 8)
				wait_drained();
			chunk++;
		end

		// Let the last responses come back, then a few more cycles for stray words.
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("** sorted_priority_queue: PASSED **");
		else
			$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

endmodule

FILE: sorted_priority_queue.f
hdl/spq_pkg.sv
hdl/spq_ifs.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
dv/tb.sv
